// ===== rtl/ffsa_pkg.sv =====
// Package: sizes, codes and the descriptor word layout of the segment allocator.
package ffsa_pkg;
	localparam int DESC_COUNT = 1024;
	localparam int ADDR_BITS  = 48;
	localparam int LEN_BITS   = 32;
	localparam int IDX_BITS   = $clog2(DESC_COUNT + 1);
	localparam int DIDX_BITS  = $clog2(DESC_COUNT);
	localparam int DESC_BITS  = ADDR_BITS + LEN_BITS + IDX_BITS;
	localparam int CFG_BITS   = 48;
	localparam logic [IDX_BITS-1:0] NIL = IDX_BITS'(DESC_COUNT);

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_FREE    = 2'd1;
	localparam logic [1:0] MODE_LOOKUP  = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_NOFIT   = 2'd2;
	localparam logic [1:0] ST_NOTALLOC = 2'd3;

	localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
	localparam logic [1:0] REG_HEAP_SIZE  = 2'd1;
	localparam logic [1:0] REG_REQ_LIMIT  = 2'd2;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]  len;
		logic [IDX_BITS-1:0]  link;
	} desc_t;
endpackage

// ===== rtl/first_fit_segment_allocator_unit.sv =====
// Top level: first-fit segment allocator with a descriptor table in one RAM.
//
// Command channel: pulse start with mode, request_size and address while busy
// is low; busy rises the next cycle and stays up until the result is shown.
// One result per command: status, address_res and length, valid for exactly
// one cycle while done is high; the receiver cannot hold results off.
// Configuration: cfg_we, cfg_index and cfg_data write heap_base, heap_size or
// request_limit at once; write only while idle.
// Walk: each step is a RAM read, then a compare. A lookup and an allocate walk
// one list; a free walks the allocated list and then the free list, at most
// DESC_COUNT steps each. Restart and early rejects go straight to the result.
// A new command may be accepted in the cycle that done is high. The single RAM
// port pair sets the rate: one descriptor read and at most one write per step.
// Reset: the allocator comes up with one free segment covering the heap given
// by the reset values of the registers; no clearing pass is needed, since only
// descriptors below the used count are ever read.
module first_fit_segment_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [31:0]                    request_size,
	input  logic [47:0]                    address,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [ffsa_pkg::CFG_BITS-1:0]  cfg_data,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [47:0]                    address_res,
	output logic [31:0]                    length
);
	import ffsa_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_AWAIT  = 4'd1;  // alloc walk: wait read
	localparam logic [3:0] S_ACHK   = 4'd2;  // alloc walk: compare
	localparam logic [3:0] S_AFIX   = 4'd3;  // alloc: unlink from prev
	localparam logic [3:0] S_FWAIT  = 4'd4;  // find in allocated list
	localparam logic [3:0] S_FCHK   = 4'd5;
	localparam logic [3:0] S_FUNL   = 4'd6;  // free: unlink prev in alloc list
	localparam logic [3:0] S_MWAIT  = 4'd7;  // free walk for merge
	localparam logic [3:0] S_MCHK   = 4'd8;
	localparam logic [3:0] S_MFIX   = 4'd9;  // relink prev: to b on free, to the remainder or next on alloc
	localparam logic [3:0] S_RESP   = 4'd10;
	localparam logic [3:0] S_PREV   = 4'd11; // read prev before rewrite

	logic [3:0]           state_q;
	logic [ADDR_BITS-1:0] heap_base_q;
	logic [LEN_BITS-1:0]  heap_size_q, req_limit_q;
	logic [IDX_BITS-1:0]  free_head_q, alloc_head_q, used_q;
	logic                 boot_q;

	logic [1:0]           mode_q;
	logic [LEN_BITS-1:0]  size_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [IDX_BITS-1:0]  cur_q, prev_q;
	logic [IDX_BITS-1:0]  steps_q;
	desc_t                b_q;       // descriptor being freed or taken
	logic [IDX_BITS-1:0]  b_idx_q;
	logic [IDX_BITS-1:0]  fix_link_q; // link to write into prev
	logic [1:0]           st_q;
	logic [ADDR_BITS-1:0] ra_q;
	logic [LEN_BITS-1:0]  rl_q;

	logic                 we;
	logic [DIDX_BITS-1:0] waddr, raddr;
	desc_t                wdata, rd;

	ffsa_ram #(.WIDTH(DESC_BITS), .DEPTH(DESC_COUNT)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
	);

	// clamp and derived values
	logic [LEN_BITS-1:0]  clamp;
	logic [ADDR_BITS-1:0] rd_end, b_end;
	assign clamp  = (request_size > req_limit_q) ? req_limit_q : request_size;
	assign rd_end = rd.start + ADDR_BITS'(rd.len);
	assign b_end  = b_q.start + ADDR_BITS'(b_q.len);
	assign busy   = (state_q != S_IDLE) || boot_q;
	assign raddr  = cur_q[DIDX_BITS-1:0];

	// read-modify-write sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_base_q  <= '0;
			heap_size_q  <= LEN_BITS'(32'h200000);
			req_limit_q  <= LEN_BITS'(32'h200000);
			free_head_q  <= '0;
			alloc_head_q <= NIL;
			used_q       <= IDX_BITS'(1);
			boot_q       <= 1'b1;
			done         <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_HEAP_BASE: heap_base_q <= cfg_data[ADDR_BITS-1:0];
					REG_HEAP_SIZE: heap_size_q <= cfg_data[LEN_BITS-1:0];
					REG_REQ_LIMIT: req_limit_q <= cfg_data[LEN_BITS-1:0];
					default: ;
				endcase
			end
			boot_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						mode_q  <= mode;
						size_q  <= clamp;
						addr_q  <= address;
						prev_q  <= NIL;
						steps_q <= '0;
						st_q    <= ST_DONE;
						ra_q    <= '0;
						rl_q    <= '0;
						case (mode)
							MODE_ALLOC: begin
								cur_q <= free_head_q;
								if (free_head_q == NIL || clamp == '0) begin
									st_q <= ST_EMPTY;
									state_q <= S_RESP;
								end else begin
									state_q <= S_AWAIT;
								end
							end
							MODE_FREE: begin
								cur_q <= alloc_head_q;
								if (address == '0 || alloc_head_q == NIL) begin
									st_q <= ST_EMPTY;
									state_q <= S_RESP;
								end else begin
									state_q <= S_FWAIT;
								end
							end
							MODE_LOOKUP: begin
								cur_q <= alloc_head_q;
								if (alloc_head_q == NIL) begin
									st_q <= ST_NOTALLOC;
									state_q <= S_RESP;
								end else begin
									state_q <= S_FWAIT;
								end
							end
							default: begin
								free_head_q  <= '0;
								alloc_head_q <= NIL;
								used_q       <= IDX_BITS'(1);
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_AWAIT: state_q <= S_ACHK;
				S_ACHK: begin
					if (rd.len >= size_q) begin
						b_idx_q <= cur_q;
						if (rd.len > size_q && used_q != NIL) begin
							// split: remainder takes the list place
							fix_link_q <= used_q;
							used_q     <= used_q + IDX_BITS'(1);
							b_q <= '{start: rd.start, len: size_q, link: alloc_head_q};
						end else begin
							fix_link_q <= rd.link;
							b_q <= '{start: rd.start, len: rd.len, link: alloc_head_q};
						end
						state_q <= S_AFIX;
					end else if (rd.link == NIL || steps_q == NIL - IDX_BITS'(1)) begin
						st_q <= ST_NOFIT;
						state_q <= S_RESP;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd.link;
						steps_q <= steps_q + IDX_BITS'(1);
						state_q <= S_AWAIT;
					end
				end
				S_AFIX: begin
					// taken descriptor written this cycle; prev is then read (S_PREV) and relinked (S_MFIX)
					alloc_head_q <= b_idx_q;
					ra_q <= b_q.start;
					rl_q <= b_q.len;
					if (prev_q == NIL) begin
						free_head_q <= fix_link_q;
						state_q <= S_RESP;
					end else begin
						cur_q   <= prev_q;
						state_q <= S_PREV;
					end
				end
				S_PREV: state_q <= S_MFIX;
				S_FWAIT: state_q <= S_FCHK;
				S_FCHK: begin
					if (rd.start == addr_q) begin
						b_q     <= rd;
						b_idx_q <= cur_q;
						ra_q    <= rd.start;
						rl_q    <= rd.len;
						if (mode_q == MODE_LOOKUP) begin
							state_q <= S_RESP;
						end else if (prev_q == NIL) begin
							alloc_head_q <= rd.link;
							cur_q   <= free_head_q;
							prev_q  <= NIL;
							steps_q <= '0;
							state_q <= (free_head_q == NIL) ? S_MFIX : S_MWAIT;
						end else begin
							fix_link_q <= rd.link;
							cur_q   <= prev_q;
							steps_q <= '0;
							state_q <= S_FUNL;
						end
					end else if (rd.link == NIL || steps_q == NIL - IDX_BITS'(1)) begin
						st_q <= ST_NOTALLOC;
						state_q <= S_RESP;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd.link;
						steps_q <= steps_q + IDX_BITS'(1);
						state_q <= S_FWAIT;
					end
				end
				S_FUNL: begin
					// wait for the read of prev, write it, then walk free list
					if (steps_q[0] == 1'b0 && mode_q == MODE_FREE && cur_q == prev_q) begin
						steps_q[0] <= 1'b1;
					end else begin
						cur_q   <= free_head_q;
						prev_q  <= NIL;
						steps_q <= '0;
						state_q <= (free_head_q == NIL) ? S_MFIX : S_MWAIT;
					end
				end
				S_MWAIT: state_q <= S_MCHK;
				S_MCHK: begin
					if (rd_end == b_q.start) begin
						state_q <= S_RESP;
					end else if (b_end == rd.start) begin
						b_q.len  <= b_q.len + rd.len;
						b_q.link <= rd.link;
						if (prev_q == NIL) begin
							free_head_q <= b_idx_q;
							state_q <= S_RESP;
						end else begin
							fix_link_q <= b_idx_q;
							cur_q   <= prev_q;
							state_q <= S_PREV;
						end
					end else if (rd.link == NIL || steps_q == NIL - IDX_BITS'(1)) begin
						b_q.link    <= free_head_q;
						free_head_q <= b_idx_q;
						state_q     <= S_RESP;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd.link;
						steps_q <= steps_q + IDX_BITS'(1);
						state_q <= S_MWAIT;
					end
				end
				S_MFIX: begin
					if (mode_q == MODE_FREE && cur_q == free_head_q && prev_q == NIL) begin
						// free list was empty: push b
						b_q.link    <= free_head_q;
						free_head_q <= b_idx_q;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					done    <= 1'b1;
					status  <= st_q;
					address_res <= (st_q == ST_DONE) ? ra_q : '0;
					length  <= (st_q == ST_DONE) ? rl_q : '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// RAM write selection
	logic boot_wr;
	assign boot_wr = boot_q || (state_q == S_IDLE && start && !busy && mode == MODE_RESTART);
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '{start: heap_base_q, len: heap_size_q, link: NIL};
		case (state_q)
			S_ACHK: begin
				if (rd.len > size_q && used_q != NIL && rd.len >= size_q) begin
					we    = 1'b1;
					waddr = used_q[DIDX_BITS-1:0];
					wdata = '{start: rd.start + ADDR_BITS'(size_q),
						len: rd.len - size_q, link: rd.link};
				end
			end
			S_AFIX: begin
				we    = 1'b1;
				waddr = b_idx_q[DIDX_BITS-1:0];
				wdata = b_q;
			end
			S_MFIX: begin
				if (mode_q == MODE_ALLOC || prev_q != NIL || cur_q != free_head_q) begin
					we    = 1'b1;
					waddr = cur_q[DIDX_BITS-1:0];
					wdata = '{start: rd.start, len: rd.len, link: fix_link_q};
				end
			end
			S_FUNL: begin
				if (steps_q[0] == 1'b1) begin
					we    = 1'b1;
					waddr = cur_q[DIDX_BITS-1:0];
					wdata = '{start: rd.start, len: rd.len, link: fix_link_q};
				end
			end
			S_MCHK: begin
				if (rd_end == b_q.start) begin
					we    = 1'b1;
					waddr = cur_q[DIDX_BITS-1:0];
					wdata = '{start: rd.start, len: rd.len + b_q.len, link: rd.link};
				end
			end
			S_RESP: begin
				if (mode_q == MODE_FREE && st_q == ST_DONE) begin
					we    = 1'b1;
					waddr = b_idx_q[DIDX_BITS-1:0];
					wdata = b_q;
				end
			end
			default: begin
				if (boot_wr) begin
					we = 1'b1;
				end
			end
		endcase
	end

	// a result strobe only ever follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result without a transaction in progress");
	// descriptor count never exceeds the table
	assert property (@(posedge clk) disable iff (!arst_n) used_q <= NIL)
		else $error("descriptor count overflow");
	// failed results carry zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (address_res == '0 && length == '0))
		else $error("nonzero payload on failed result");
endmodule

// ===== rtl/ffsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
